// ===== hdl/aabc_pkg.sv =====
// ----------------------------------------------------------------------------
// aabc_pkg
// Shared types and constants of the alarm annunciator blink controller:
// status and pause codes, register indexes, reset values and pause lengths.
// ----------------------------------------------------------------------------
package aabc_pkg;

    // Width of one configuration register
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Pause down-counter width and pause lengths in ticks
    localparam int PAUSE_W = 26;
    localparam logic [PAUSE_W-1:0] FULL_PAUSE_MS = PAUSE_W'(12 * 60 * 60 * 1000);
    localparam logic [PAUSE_W-1:0] BUZZ_PAUSE_MS = PAUSE_W'(30 * 60 * 1000);

    // Pin bit positions
    localparam int PIN_BLUE   = 0;
    localparam int PIN_ORANGE = 1;
    localparam int PIN_RED    = 2;
    localparam int PIN_BUZZ   = 3;

    // Alarm status, in rising priority
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SENSOR = 3'd1,
        ST_LINK   = 3'd2,
        ST_MAIN   = 3'd3,
        ST_BACKUP = 3'd4
    } status_t;

    // Pause level
    typedef enum logic [1:0] {
        PAUSE_NONE = 2'd0,
        PAUSE_BUZZ = 2'd1,
        PAUSE_FULL = 2'd2
    } pause_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_DARK   = 3'd0,
        REG_LONG_LIT    = 3'd1,
        REG_SHORT_DARK  = 3'd2,
        REG_SHORT_LIT   = 3'd3,
        REG_BUZZ_SOUND  = 3'd4,
        REG_BUZZ_QUIET  = 3'd5,
        REG_LONG_PRESS  = 3'd6,
        REG_SHORT_PRESS = 3'd7
    } reg_idx_t;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_LONG_DARK   = 16'd2000;
    localparam logic [CFG_W-1:0] RST_LONG_LIT    = 16'd400;
    localparam logic [CFG_W-1:0] RST_SHORT_DARK  = 16'd200;
    localparam logic [CFG_W-1:0] RST_SHORT_LIT   = 16'd75;
    localparam logic [CFG_W-1:0] RST_BUZZ_SOUND  = 16'd500;
    localparam logic [CFG_W-1:0] RST_BUZZ_QUIET  = 16'd200;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS  = 16'd5000;
    localparam logic [CFG_W-1:0] RST_SHORT_PRESS = 16'd500;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0] long_dark_ms;
        logic [CFG_W-1:0] long_lit_ms;
        logic [CFG_W-1:0] short_dark_ms;
        logic [CFG_W-1:0] short_lit_ms;
        logic [CFG_W-1:0] buzz_sound_ms;
        logic [CFG_W-1:0] buzz_quiet_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] short_press_ms;
    } cfg_t;

endpackage

// ===== hdl/aabc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// aabc_cfg_regs
// Configuration register file: eight 16-bit timing registers, written one
// beat at a time through the configuration channel.
// ----------------------------------------------------------------------------
module aabc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [aabc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [aabc_pkg::CFG_W-1:0]          wr_data,
    output aabc_pkg::cfg_t                      cfg
);

    aabc_pkg::cfg_t cfg_reg;

    // Write the addressed register on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_dark_ms   <= aabc_pkg::RST_LONG_DARK;
            cfg_reg.long_lit_ms    <= aabc_pkg::RST_LONG_LIT;
            cfg_reg.short_dark_ms  <= aabc_pkg::RST_SHORT_DARK;
            cfg_reg.short_lit_ms   <= aabc_pkg::RST_SHORT_LIT;
            cfg_reg.buzz_sound_ms  <= aabc_pkg::RST_BUZZ_SOUND;
            cfg_reg.buzz_quiet_ms  <= aabc_pkg::RST_BUZZ_QUIET;
            cfg_reg.long_press_ms  <= aabc_pkg::RST_LONG_PRESS;
            cfg_reg.short_press_ms <= aabc_pkg::RST_SHORT_PRESS;
        end
        else if (wr_en)
        begin
            unique case (aabc_pkg::reg_idx_t'(wr_index))
                aabc_pkg::REG_LONG_DARK:   cfg_reg.long_dark_ms   <= wr_data;
                aabc_pkg::REG_LONG_LIT:    cfg_reg.long_lit_ms    <= wr_data;
                aabc_pkg::REG_SHORT_DARK:  cfg_reg.short_dark_ms  <= wr_data;
                aabc_pkg::REG_SHORT_LIT:   cfg_reg.short_lit_ms   <= wr_data;
                aabc_pkg::REG_BUZZ_SOUND:  cfg_reg.buzz_sound_ms  <= wr_data;
                aabc_pkg::REG_BUZZ_QUIET:  cfg_reg.buzz_quiet_ms  <= wr_data;
                aabc_pkg::REG_LONG_PRESS:  cfg_reg.long_press_ms  <= wr_data;
                aabc_pkg::REG_SHORT_PRESS: cfg_reg.short_press_ms <= wr_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/aabc_blink.sv =====
// ----------------------------------------------------------------------------
// aabc_blink
// Status priority update, saturating blink timers and blink phases for the
// blue, orange and red LEDs and the buzzer. Produces the pin levels after
// the blink stage of one tick.
// ----------------------------------------------------------------------------
module aabc_blink #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                main_power_ok,
    input  logic                backup_power_ok,
    input  logic                sensor_valid,
    input  logic                link_up,
    input  aabc_pkg::cfg_t      cfg,
    input  aabc_pkg::pause_t    pause_cur,
    input  logic [3:0]          pin_cur,
    output aabc_pkg::status_t   status_next,
    output logic [3:0]          pin_mid
);

    localparam int CW = (TIMER_WIDTH > aabc_pkg::CFG_W) ? TIMER_WIDTH : aabc_pkg::CFG_W;

    aabc_pkg::status_t      status_reg;
    logic                   blue_phase_reg, orange_phase_reg, red_phase_reg, buzz_phase_reg;
    logic                   blue_phase_next, orange_phase_next, red_phase_next, buzz_phase_next;
    logic [TIMER_WIDTH-1:0] blue_elapsed_reg, orange_elapsed_reg;
    logic [TIMER_WIDTH-1:0] red_elapsed_reg, buzz_elapsed_reg;
    logic [TIMER_WIDTH-1:0] blue_elapsed_next, orange_elapsed_next;
    logic [TIMER_WIDTH-1:0] red_elapsed_next, buzz_elapsed_next;
    logic [TIMER_WIDTH-1:0] blue_inc, orange_inc, red_inc, buzz_inc;

    function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

    // True when the timer has run out for the current phase
    function automatic logic due(input logic [TIMER_WIDTH-1:0] e, input logic ph,
                                 input logic [aabc_pkg::CFG_W-1:0] off,
                                 input logic [aabc_pkg::CFG_W-1:0] on);
        due = ph ? (CW'(e) >= CW'(on)) : (CW'(e) >= CW'(off));
    endfunction

    // Resolve status by priority; link fault is left only for ok
    always_comb
    begin
        status_next = status_reg;
        if (!backup_power_ok)
            status_next = aabc_pkg::ST_BACKUP;
        else if (!main_power_ok)
            status_next = aabc_pkg::ST_MAIN;
        else if (status_next != aabc_pkg::ST_SENSOR && status_next != aabc_pkg::ST_LINK)
            status_next = aabc_pkg::ST_OK;
        if (!sensor_valid && status_next == aabc_pkg::ST_OK)
            status_next = aabc_pkg::ST_SENSOR;
        else if (sensor_valid && status_next == aabc_pkg::ST_SENSOR)
            status_next = aabc_pkg::ST_OK;
        if (!link_up && status_next <= aabc_pkg::ST_LINK)
            status_next = aabc_pkg::ST_LINK;
        else if (status_next == aabc_pkg::ST_LINK)
            status_next = aabc_pkg::ST_OK;
    end

    // Count all timers up
    assign blue_inc   = sat_inc(blue_elapsed_reg);
    assign orange_inc = sat_inc(orange_elapsed_reg);
    assign red_inc    = sat_inc(red_elapsed_reg);
    assign buzz_inc   = sat_inc(buzz_elapsed_reg);

    // Blink stage: toggle the blinkers the status drives and update pins
    always_comb
    begin
        blue_phase_next     = blue_phase_reg;
        orange_phase_next   = orange_phase_reg;
        red_phase_next      = red_phase_reg;
        buzz_phase_next     = buzz_phase_reg;
        blue_elapsed_next   = blue_inc;
        orange_elapsed_next = orange_inc;
        red_elapsed_next    = red_inc;
        buzz_elapsed_next   = buzz_inc;
        pin_mid             = pin_cur;
        case (status_next)
            aabc_pkg::ST_OK:
            begin
                if (due(blue_inc, blue_phase_reg, cfg.long_dark_ms, cfg.long_lit_ms))
                begin
                    blue_elapsed_next             = '0;
                    blue_phase_next               = !blue_phase_reg;
                    pin_mid[aabc_pkg::PIN_BLUE]   = !blue_phase_reg;
                    pin_mid[aabc_pkg::PIN_ORANGE] = 1'b0;
                    pin_mid[aabc_pkg::PIN_RED]    = 1'b0;
                    pin_mid[aabc_pkg::PIN_BUZZ]   = 1'b0;
                end
            end
            aabc_pkg::ST_SENSOR:
            begin
                if (due(blue_inc, blue_phase_reg, cfg.short_dark_ms, cfg.short_lit_ms))
                begin
                    blue_elapsed_next           = '0;
                    blue_phase_next             = !blue_phase_reg;
                    pin_mid[aabc_pkg::PIN_BLUE] = !blue_phase_reg;
                end
                if (due(orange_inc, orange_phase_reg, cfg.long_dark_ms, cfg.long_lit_ms))
                begin
                    orange_elapsed_next           = '0;
                    orange_phase_next             = !orange_phase_reg;
                    pin_mid[aabc_pkg::PIN_ORANGE] = !orange_phase_reg;
                    pin_mid[aabc_pkg::PIN_RED]    = 1'b0;
                    pin_mid[aabc_pkg::PIN_BUZZ]   = 1'b0;
                end
            end
            aabc_pkg::ST_LINK:
            begin
                if (due(blue_inc, blue_phase_reg, cfg.short_dark_ms, cfg.short_lit_ms))
                begin
                    blue_elapsed_next           = '0;
                    blue_phase_next             = !blue_phase_reg;
                    pin_mid[aabc_pkg::PIN_BLUE] = !blue_phase_reg;
                end
                if (due(red_inc, red_phase_reg, cfg.long_dark_ms, cfg.long_lit_ms))
                begin
                    red_elapsed_next              = '0;
                    red_phase_next                = !red_phase_reg;
                    pin_mid[aabc_pkg::PIN_RED]    = !red_phase_reg;
                    pin_mid[aabc_pkg::PIN_ORANGE] = 1'b0;
                    pin_mid[aabc_pkg::PIN_BUZZ]   = 1'b0;
                end
            end
            aabc_pkg::ST_MAIN:
            begin
                if (due(orange_inc, orange_phase_reg, cfg.short_dark_ms, cfg.short_lit_ms))
                begin
                    orange_elapsed_next           = '0;
                    orange_phase_next             = !orange_phase_reg;
                    pin_mid[aabc_pkg::PIN_ORANGE] = !orange_phase_reg;
                    pin_mid[aabc_pkg::PIN_BLUE]   = 1'b0;
                    pin_mid[aabc_pkg::PIN_RED]    = 1'b0;
                    pin_mid[aabc_pkg::PIN_BUZZ]   = 1'b0;
                end
            end
            default:
            begin
                if (due(red_inc, red_phase_reg, cfg.short_dark_ms, cfg.short_lit_ms))
                begin
                    red_elapsed_next              = '0;
                    red_phase_next                = !red_phase_reg;
                    pin_mid[aabc_pkg::PIN_RED]    = !red_phase_reg;
                    pin_mid[aabc_pkg::PIN_BLUE]   = 1'b0;
                    pin_mid[aabc_pkg::PIN_ORANGE] = 1'b0;
                end
                // Buzzer blinks only while no pause is running
                if (pause_cur == aabc_pkg::PAUSE_NONE &&
                    due(buzz_inc, buzz_phase_reg, cfg.buzz_quiet_ms, cfg.buzz_sound_ms))
                begin
                    buzz_elapsed_next           = '0;
                    buzz_phase_next             = !buzz_phase_reg;
                    pin_mid[aabc_pkg::PIN_BUZZ] = !buzz_phase_reg;
                end
            end
        endcase
    end

    // Hold status, phases and timers; advance once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg         <= aabc_pkg::ST_OK;
            blue_phase_reg     <= 1'b1;
            orange_phase_reg   <= 1'b1;
            red_phase_reg      <= 1'b1;
            buzz_phase_reg     <= 1'b1;
            blue_elapsed_reg   <= '0;
            orange_elapsed_reg <= '0;
            red_elapsed_reg    <= '0;
            buzz_elapsed_reg   <= '0;
        end
        else if (advance)
        begin
            status_reg         <= status_next;
            blue_phase_reg     <= blue_phase_next;
            orange_phase_reg   <= orange_phase_next;
            red_phase_reg      <= red_phase_next;
            buzz_phase_reg     <= buzz_phase_next;
            blue_elapsed_reg   <= blue_elapsed_next;
            orange_elapsed_reg <= orange_elapsed_next;
            red_elapsed_reg    <= red_elapsed_next;
            buzz_elapsed_reg   <= buzz_elapsed_next;
        end
    end

endmodule

// ===== hdl/aabc_button.sv =====
// ----------------------------------------------------------------------------
// aabc_button
// Stop-button hold counter and pause timer. A short press pauses the buzzer,
// a long press pauses buzzer and beacon; pauses count down and expire.
// ----------------------------------------------------------------------------
module aabc_button #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                button_pressed,
    input  aabc_pkg::cfg_t      cfg,
    input  logic                buzz_mid,
    output aabc_pkg::pause_t    pause_cur,
    output aabc_pkg::pause_t    pause_next,
    output logic                buzz_final
);

    localparam int CW = (TIMER_WIDTH > aabc_pkg::CFG_W) ? TIMER_WIDTH : aabc_pkg::CFG_W;

    aabc_pkg::pause_t               pause_mode_reg;
    logic [aabc_pkg::PAUSE_W-1:0]   remaining_reg, remaining_next;
    logic [TIMER_WIDTH-1:0]         hold_count_reg, hold_count_next, hold_inc;
    logic                           was_down_reg, was_down_next;
    logic                           over_long, over_short;

    assign hold_inc   = (&hold_count_reg) ? hold_count_reg : hold_count_reg + 1'b1;
    assign over_short = CW'(hold_count_reg) > CW'(cfg.short_press_ms);

    // Compare against the count this tick leaves: incremented while held
    assign over_long  = button_pressed ? (CW'(hold_inc) > CW'(cfg.long_press_ms))
                                       : (CW'(hold_count_reg) > CW'(cfg.long_press_ms));

    // Expire or count down the pause, then act on the button
    always_comb
    begin
        pause_next      = pause_mode_reg;
        remaining_next  = remaining_reg;
        buzz_final      = buzz_mid;
        if (remaining_reg == '0)
            pause_next = aabc_pkg::PAUSE_NONE;
        else
            remaining_next = remaining_reg - 1'b1;

        if (button_pressed)
        begin
            hold_count_next = hold_inc;
            was_down_next   = 1'b1;
            if (over_long && pause_next != aabc_pkg::PAUSE_FULL)
                buzz_final = 1'b1;
        end
        else
        begin
            if (was_down_reg)
            begin
                if (over_long && pause_next != aabc_pkg::PAUSE_FULL)
                begin
                    pause_next     = aabc_pkg::PAUSE_FULL;
                    remaining_next = aabc_pkg::FULL_PAUSE_MS;
                    buzz_final     = 1'b0;
                end
                else if (over_short && pause_next == aabc_pkg::PAUSE_NONE)
                begin
                    pause_next     = aabc_pkg::PAUSE_BUZZ;
                    remaining_next = aabc_pkg::BUZZ_PAUSE_MS;
                    buzz_final     = 1'b0;
                end
            end
            hold_count_next = '0;
            was_down_next   = 1'b0;
        end
    end

    assign pause_cur = pause_mode_reg;

    // Hold pause and press state; advance once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_mode_reg <= aabc_pkg::PAUSE_NONE;
            remaining_reg  <= '0;
            hold_count_reg <= '0;
            was_down_reg   <= 1'b0;
        end
        else if (advance)
        begin
            pause_mode_reg <= pause_next;
            remaining_reg  <= remaining_next;
            hold_count_reg <= hold_count_next;
            was_down_reg   <= was_down_next;
        end
    end

endmodule

// ===== hdl/alarm_annunciator_blink_controller.sv =====
// ----------------------------------------------------------------------------
// alarm_annunciator_blink_controller
// One millisecond tick per input beat: priority alarm status, LED and buzzer
// blink patterns, red beacon and timed pauses from the stop button.
//
//   channel  handshake              payload
//   -------  ---------------------  ----------------------------------------
//   in       in_valid / in_ready    main_power_ok backup_power_ok
//                                   sensor_valid link_up button_pressed
//   out      out_valid / out_ready  blue_led orange_led red_led buzzer_on
//                                   beacon_on status_code pause_level
//   cfg      cfg_valid / cfg_ready  cfg_index cfg_data
//
// Each tick is worked out combinationally from the held state and the input
// beat and is registered into the output register; one beat per cycle while in_ready is high.
// in_ready is high whenever the output register is empty or being taken.
// cfg_ready is always high; a write goes straight into the register file.
// Reset clears all state but the result registers at once; no clearing pass.
// ----------------------------------------------------------------------------
module alarm_annunciator_blink_controller #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            main_power_ok,
    input  logic                            backup_power_ok,
    input  logic                            sensor_valid,
    input  logic                            link_up,
    input  logic                            button_pressed,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            blue_led,
    output logic                            orange_led,
    output logic                            red_led,
    output logic                            buzzer_on,
    output logic                            beacon_on,
    output logic [2:0]                      status_code,
    output logic [1:0]                      pause_level,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aabc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aabc_pkg::CFG_W-1:0]      cfg_data
);

    aabc_pkg::cfg_t     cfg;
    aabc_pkg::status_t  status_next;
    aabc_pkg::pause_t   pause_cur, pause_next;
    logic [3:0]         pin_levels_reg, pin_mid, pin_next;
    logic               buzz_final, advance;
    logic               out_valid_reg;
    logic [3:0]         pins_out_reg;
    logic               beacon_reg;
    logic [2:0]         status_reg;
    logic [1:0]         pause_reg;

    // Accept a tick when the output register is free or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign advance   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    aabc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    aabc_blink #(.TIMER_WIDTH(TIMER_WIDTH)) u_blink (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .main_power_ok   (main_power_ok),
        .backup_power_ok (backup_power_ok),
        .sensor_valid    (sensor_valid),
        .link_up         (link_up),
        .cfg             (cfg),
        .pause_cur       (pause_cur),
        .pin_cur         (pin_levels_reg),
        .status_next     (status_next),
        .pin_mid         (pin_mid)
    );

    aabc_button #(.TIMER_WIDTH(TIMER_WIDTH)) u_button (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .button_pressed (button_pressed),
        .cfg            (cfg),
        .buzz_mid       (pin_mid[aabc_pkg::PIN_BUZZ]),
        .pause_cur      (pause_cur),
        .pause_next     (pause_next),
        .buzz_final     (buzz_final)
    );

    // Merge the button stage's buzzer drive into the pin levels
    always_comb
    begin
        pin_next                     = pin_mid;
        pin_next[aabc_pkg::PIN_BUZZ] = buzz_final;
    end

    // Hold pin levels across ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pin_levels_reg <= '0;
        else if (advance)
            pin_levels_reg <= pin_next;
    end

    // Output valid: set on an accepted tick, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pins_out_reg <= pin_next;
            beacon_reg   <= (status_next == aabc_pkg::ST_BACKUP) &&
                            (pause_cur != aabc_pkg::PAUSE_FULL);
            status_reg   <= status_next;
            pause_reg    <= pause_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign blue_led    = pins_out_reg[aabc_pkg::PIN_BLUE];
    assign orange_led  = pins_out_reg[aabc_pkg::PIN_ORANGE];
    assign red_led     = pins_out_reg[aabc_pkg::PIN_RED];
    assign buzzer_on   = pins_out_reg[aabc_pkg::PIN_BUZZ];
    assign beacon_on   = beacon_reg;
    assign status_code = status_reg;
    assign pause_level = pause_reg;

endmodule

// ===== hdl/aabc_checker.sv =====
// ----------------------------------------------------------------------------
// aabc_checker
// Port-level checks of the alarm annunciator blink controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module aabc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            beacon_on,
    input  logic [2:0]                      status_code,
    input  logic [1:0]                      pause_level
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status_code) && $stable(pause_level))
        else $error("stalled result beat changed");

    // Every accepted tick yields a result on the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick gave no result");

    // Accept while the output register is empty
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Beacon only on backup loss
    a_beacon: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && beacon_on |-> status_code == aabc_pkg::ST_BACKUP)
        else $error("beacon lit outside backup loss");

endmodule

bind alarm_annunciator_blink_controller aabc_checker u_aabc_checker (.*);
